// ----- design/running_median_two_heaps_assert.svh -----
// Assertion macros for the running median block.
// Used by the port checker; no other dependencies.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbl failed");
`define RMH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");
`endif

// ----- design/rmh_pkg.sv -----
// Package for the running median block: widths, types, sequencer states.
// No dependencies.
package rmh_pkg;
  localparam int Capacity = 1024;
  localparam int SampleBits = 16;
  localparam int HeapDepth = Capacity / 2 + 2;
  localparam int AddrBits = $clog2(HeapDepth);
  localparam int CntBits = $clog2(HeapDepth + 1);
  localparam int HeldBits = 11;
  localparam int TotBits = $clog2(Capacity + 1) + 1;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic last_in_stream;
  } rmh_in_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] median;
    logic overflow;
    logic [HeldBits-1:0] held_count;
  } rmh_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHOOSE, ST_PUSH, ST_UP_RD, ST_UP_CMP, ST_BAL,
    ST_POP_RD, ST_DN_RD, ST_DN_CMP, ST_MED_RD, ST_MED, ST_OUT
  } rmh_state_t;
endpackage

// ----- design/running_median_two_heaps.sv -----
// Running median of a signed stream with a max-heap and a min-heap in RAM.
// out_valid rises once the sift-up and sift-down loops, run over one RAM port per heap,
// are done; a dropped sample skips both loops and only reads the two heap tops.
// One transaction at a time: in_stall is high from acceptance until the cycle after
// the result is taken.
// Synchronous active-low reset clears both heap counts; heap RAM is not cleared.
module running_median_two_heaps (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rmh_pkg::rmh_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rmh_pkg::rmh_out_t out_data
);
  import rmh_pkg::*;

  rmh_state_t state_r, state_nxt;
  logic [CntBits-1:0] lcnt_r, lcnt_nxt, ucnt_r, ucnt_nxt;
  logic signed [SampleBits-1:0] samp_r, samp_nxt, val_r, val_nxt, tmp_r, tmp_nxt;
  logic signed [SampleBits-1:0] ltop_r, ltop_nxt;
  logic last_r, last_nxt, drop_r, drop_nxt;
  logic sel_r, sel_nxt;
  logic bal_r, bal_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [AddrBits-1:0] idx_r, idx_nxt, ch_r, ch_nxt;
  logic [CntBits-1:0] n_r, n_nxt;
  rmh_out_t res_r, res_nxt;

  logic we_l, we_u;
  logic [AddrBits-1:0] addr;
  logic signed [SampleBits-1:0] wdata, rd_l, rd_u, rd;
  logic [TotBits-1:0] held;
  logic signed [SampleBits:0] sum;
  logic [CntBits-1:0] cnt_sel;
  logic [AddrBits:0] lidx, ridx;
  logic better;

  rmh_ram #(.Width(SampleBits), .Depth(HeapDepth)) u_lower (
    .clk(clk), .we(we_l), .addr(addr), .wdata(wdata), .rdata(rd_l));
  rmh_ram #(.Width(SampleBits), .Depth(HeapDepth)) u_upper (
    .clk(clk), .we(we_u), .addr(addr), .wdata(wdata), .rdata(rd_u));

  assign rd = sel_r ? rd_u : rd_l;
  assign held = TotBits'(lcnt_r) + TotBits'(ucnt_r);
  assign cnt_sel = sel_r ? ucnt_r : lcnt_r;
  assign lidx = {idx_r, 1'b1};
  assign ridx = lidx + 1'b1;
  // The value rd ranks above val: larger in the lower heap, smaller in the upper.
  assign better = sel_r ? (rd < val_r) : (rd > val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lcnt_r <= '0;
      ucnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      lcnt_r <= lcnt_nxt;
      ucnt_r <= ucnt_nxt;
    end
    samp_r <= samp_nxt; val_r <= val_nxt; tmp_r <= tmp_nxt; ltop_r <= ltop_nxt;
    last_r <= last_nxt; drop_r <= drop_nxt; sel_r <= sel_nxt; bal_r <= bal_nxt;
    ph_r <= ph_nxt; idx_r <= idx_nxt; ch_r <= ch_nxt; n_r <= n_nxt; res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    lcnt_nxt = lcnt_r; ucnt_nxt = ucnt_r;
    samp_nxt = samp_r; val_nxt = val_r; tmp_nxt = tmp_r; ltop_nxt = ltop_r;
    last_nxt = last_r; drop_nxt = drop_r; sel_nxt = sel_r; bal_nxt = bal_r;
    ph_nxt = ph_r; idx_nxt = idx_r; ch_nxt = ch_r; n_nxt = n_r; res_nxt = res_r;
    we_l = 1'b0; we_u = 1'b0; addr = idx_r; wdata = val_r;
    sum = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          samp_nxt = in_data.sample;
          last_nxt = in_data.last_in_stream;
          drop_nxt = (held >= TotBits'(Capacity));
          sel_nxt = 1'b0;
          addr = '0;
          state_nxt = ST_CHOOSE;
        end
      end
      ST_CHOOSE: begin
        // RAM output now holds the lower top.
        if (drop_r) begin
          sel_nxt = 1'b0; addr = '0; state_nxt = ST_MED_RD;
        end else begin
          sel_nxt = !(lcnt_r == '0 || samp_r <= rd_l);
          val_nxt = samp_r; bal_nxt = 1'b0; state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        idx_nxt = AddrBits'(cnt_sel);
        addr = AddrBits'(cnt_sel);
        if (sel_r) begin
          we_u = 1'b1; ucnt_nxt = ucnt_r + 1'b1;
        end else begin
          we_l = 1'b1; lcnt_nxt = lcnt_r + 1'b1;
        end
        state_nxt = ST_UP_RD;
      end
      ST_UP_RD: begin
        if (idx_r == '0) begin
          state_nxt = ST_BAL;
        end else begin
          ch_nxt = (idx_r - 1'b1) >> 1;
          addr = (idx_r - 1'b1) >> 1;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        addr = ch_r;
        if (!better) begin
          // rd is parent; stop if val does not rank above it.
          state_nxt = ST_BAL;
        end
        if (sel_r ? (val_r < rd) : (val_r > rd)) begin
          addr = idx_r; wdata = rd;
          we_l = !sel_r; we_u = sel_r;
          idx_nxt = ch_r;
          state_nxt = ST_PUSH;
          ph_nxt = 2'd1;
        end else begin
          state_nxt = ST_BAL;
        end
        if (state_nxt == ST_PUSH) begin
          state_nxt = ST_UP_RD;
          addr = idx_r;
        end
      end
      ST_BAL: begin
        // Write value at its final sift-up place.
        addr = idx_r;
        we_l = !sel_r; we_u = sel_r;
        if (bal_r) begin
          sel_nxt = 1'b0; state_nxt = ST_MED_RD;
        end else if (lcnt_r > ucnt_r + 1'b1) begin
          sel_nxt = 1'b0; bal_nxt = 1'b1; state_nxt = ST_POP_RD; ph_nxt = 2'd0;
        end else if (ucnt_r > lcnt_r + 1'b1) begin
          sel_nxt = 1'b1; bal_nxt = 1'b1; state_nxt = ST_POP_RD; ph_nxt = 2'd0;
        end else begin
          sel_nxt = 1'b0; state_nxt = ST_MED_RD;
        end
      end
      ST_POP_RD: begin
        // Phase 0: read top; 1: take top, read last; 2: take last.
        case (ph_r)
          2'd0: begin
            addr = '0; ph_nxt = 2'd1;
          end
          2'd1: begin
            tmp_nxt = rd;
            addr = AddrBits'(cnt_sel - 1'b1);
            n_nxt = cnt_sel - 1'b1;
            if (sel_r) ucnt_nxt = ucnt_r - 1'b1;
            else lcnt_nxt = lcnt_r - 1'b1;
            ph_nxt = 2'd2;
          end
          default: begin
            val_nxt = rd; idx_nxt = '0; ph_nxt = 2'd0;
            state_nxt = ST_DN_RD;
          end
        endcase
      end
      ST_DN_RD: begin
        // Phase 0: read left; 1: note left, read right; 2: pick the better child.
        case (ph_r)
          2'd0: begin
            if (lidx >= (AddrBits + 1)'(n_r)) begin
              addr = idx_r; we_l = !sel_r; we_u = sel_r;
              state_nxt = ST_DN_CMP; ph_nxt = 2'd3;
            end else begin
              addr = lidx[AddrBits-1:0]; ph_nxt = 2'd1;
            end
          end
          2'd1: begin
            ltop_nxt = rd; ch_nxt = lidx[AddrBits-1:0];
            if (ridx < (AddrBits + 1)'(n_r)) begin
              addr = ridx[AddrBits-1:0]; ph_nxt = 2'd2;
            end else begin
              state_nxt = ST_DN_CMP; ph_nxt = 2'd0;
            end
          end
          default: begin
            if (sel_r ? (rd < ltop_r) : (rd > ltop_r)) begin
              ltop_nxt = rd; ch_nxt = ridx[AddrBits-1:0];
            end
            state_nxt = ST_DN_CMP; ph_nxt = 2'd0;
          end
        endcase
      end
      ST_DN_CMP: begin
        if (ph_r == 2'd3) begin
          // Sift-down finished; push popped top into the other heap.
          sel_nxt = !sel_r; val_nxt = tmp_r; state_nxt = ST_PUSH; ph_nxt = 2'd0;
        end else if (sel_r ? (ltop_r < val_r) : (ltop_r > val_r)) begin
          addr = idx_r; wdata = ltop_r; we_l = !sel_r; we_u = sel_r;
          idx_nxt = ch_r; state_nxt = ST_DN_RD; ph_nxt = 2'd0;
        end else begin
          addr = idx_r; we_l = !sel_r; we_u = sel_r;
          sel_nxt = !sel_r; val_nxt = tmp_r; state_nxt = ST_PUSH; ph_nxt = 2'd0;
        end
      end
      ST_MED_RD: begin
        addr = '0; state_nxt = ST_MED;
      end
      ST_MED: begin
        res_nxt.overflow = drop_r;
        res_nxt.held_count = HeldBits'(held);
        sum = (SampleBits + 1)'(rd_l) + (SampleBits + 1)'(rd_u);
        if (held[0]) begin
          res_nxt.median = (lcnt_r > ucnt_r) ? rd_l : rd_u;
        end else if (lcnt_r != '0 && ucnt_r != '0) begin
          res_nxt.median = SampleBits'((sum + (SampleBits + 1)'(sum[SampleBits])) >>> 1);
        end else begin
          res_nxt.median = '0;
        end
        if (last_r) begin
          lcnt_nxt = '0; ucnt_nxt = '0;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data = res_r;
endmodule

// ----- design/rmh_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module rmh_ram #(
  parameter int Width = 16,
  parameter int Depth = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- design/rmh_checker.sv -----
// Port-level checker for the running median block, bound to the top level.
// Depends on rmh_pkg and running_median_two_heaps_assert.svh.
`include "running_median_two_heaps_assert.svh"
module rmh_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input rmh_pkg::rmh_out_t out_data
);
  import rmh_pkg::*;

  `RMH_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RMH_ASSERT_NOW(a_no_accept_with_result, out_valid, in_stall)
  `RMH_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(out_data))
  `RMH_ASSERT_NOW(a_held_range, out_valid, out_data.held_count <= HeldBits'(Capacity))
endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

// ----- verif/running_median_two_heaps_test.sv -----
// Self-checking testbench for running_median_two_heaps: drives signed samples,
// predicts each median with its own pair of heaps, and compares every result.
// Depends on rmh_pkg and the running_median_two_heaps module.
`timescale 1ns / 100ps

module running_median_two_heaps_test;
  import rmh_pkg::*;

  localparam int Cap = Capacity;
  localparam int Depth = Cap / 2 + 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rmh_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rmh_out_t out_data;

  running_median_two_heaps DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  rmh_in_t pending_samples[$];
  rmh_out_t expected_medians[$];
  int errors = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;

  int lo_heap[Depth];
  int hi_heap[Depth];
  int lo_n = 0;
  int hi_n = 0;

  function automatic bit outranks(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_insert(ref int h[Depth], ref int n, input int v, input bit is_max);
    int i;
    int p;
    int t;
    i = n;
    h[i] = v;
    n = n + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endtask

  task automatic heap_remove(ref int h[Depth], ref int n, input bit is_max, output int top);
    int i;
    int l;
    int best;
    int t;
    top = h[0];
    n = n - 1;
    h[0] = h[n];
    i = 0;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && outranks(h[l], h[best], is_max)) best = l;
      if (l + 1 < n && outranks(h[l + 1], h[best], is_max)) best = l + 1;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
  endtask

  task automatic predict_median(input rmh_in_t item);
    rmh_out_t r;
    int s;
    int t;
    int held;
    s = item.sample;
    r = '0;
    if (lo_n + hi_n >= Cap) begin
      r.overflow = 1'b1;
    end else begin
      if (lo_n == 0 || s <= lo_heap[0]) heap_insert(lo_heap, lo_n, s, 1'b1);
      else heap_insert(hi_heap, hi_n, s, 1'b0);
      if (lo_n > hi_n + 1) begin
        heap_remove(lo_heap, lo_n, 1'b1, t);
        heap_insert(hi_heap, hi_n, t, 1'b0);
      end else if (hi_n > lo_n + 1) begin
        heap_remove(hi_heap, hi_n, 1'b0, t);
        heap_insert(lo_heap, lo_n, t, 1'b1);
      end
    end
    held = lo_n + hi_n;
    if (held % 2 == 1) r.median = SampleBits'((lo_n > hi_n) ? lo_heap[0] : hi_heap[0]);
    else if (lo_n > 0 && hi_n > 0) r.median = SampleBits'((lo_heap[0] + hi_heap[0]) / 2);
    r.held_count = held[HeldBits-1:0];
    expected_medians.push_back(r);
    if (item.last_in_stream) begin
      lo_n = 0;
      hi_n = 0;
    end
  endtask

  function automatic rmh_in_t make_sample(int v, bit last);
    rmh_in_t it;
    it.sample = v[SampleBits-1:0];
    it.last_in_stream = last;
    return it;
  endfunction

  initial begin
    int len;
    int base;
    int span;
    pending_samples.push_back(make_sample(-32768, 1'b0));
    pending_samples.push_back(make_sample(32767, 1'b0));
    pending_samples.push_back(make_sample(32767, 1'b0));
    pending_samples.push_back(make_sample(-32768, 1'b0));
    pending_samples.push_back(make_sample(-1, 1'b0));
    pending_samples.push_back(make_sample(0, 1'b0));
    pending_samples.push_back(make_sample(0, 1'b0));
    pending_samples.push_back(make_sample(0, 1'b1));
    pending_samples.push_back(make_sample(-3, 1'b0));
    pending_samples.push_back(make_sample(0, 1'b0));
    pending_samples.push_back(make_sample(5, 1'b0));
    pending_samples.push_back(make_sample(5, 1'b0));
    pending_samples.push_back(make_sample(-5, 1'b1));
    pending_samples.push_back(make_sample(7, 1'b1));
    // Fill the store to capacity, then push past it and end on a dropped sample.
    for (int i = 0; i < Cap + 3; i++)
      pending_samples.push_back(make_sample($urandom_range(0, 65535) - 32768, i == Cap + 2));
    while (pending_samples.size() < 1750) begin
      len = $urandom_range(1, 40);
      base = $urandom_range(0, 65535) - 32768;
      span = 1 << $urandom_range(0, 16);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0)
          pending_samples.push_back(make_sample($urandom_range(0, 65535) - 32768, i == len - 1));
        else
          pending_samples.push_back(make_sample(base + $urandom_range(0, span - 1),
                                                i == len - 1));
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int hold_count = 0;
  int sent = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_median(in_data);
        sent = sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_data <= pending_samples.pop_front();
          in_valid <= 1'b1;
          send_gap = $urandom_range(0, 19);
        end else begin
          in_valid <= 1'b0;
          stimulus_done = 1'b1;
        end
      end
    end
  end

  // The receiver holds off for long stretches now and then while the sender keeps offering.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
      end else if (hold_count < 3 && sent > 100 + 400 * hold_count) begin
        hold_left = 400;
        hold_count = hold_count + 1;
      end
      hold_off <= hold_left > 0;
    end
  end

  always @(posedge clk) begin
    rmh_out_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors = errors + 1;
        end else begin
          exp_r = expected_medians.pop_front();
          if (out_data.median !== exp_r.median || out_data.overflow !== exp_r.overflow ||
              out_data.held_count !== exp_r.held_count) begin
            $display("%0t: expected %0d/%0b/%0d, got %0d/%0b/%0d", $time,
                     exp_r.median, exp_r.overflow, exp_r.held_count,
                     out_data.median, out_data.overflow, out_data.held_count);
            errors = errors + 1;
          end
        end
        recv_gap = $urandom_range(0, 19);
      end
      if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  initial begin
    wait (stimulus_done && !in_valid && expected_medians.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_medians.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+design
design/rmh_pkg.sv
design/rmh_ram.sv
design/running_median_two_heaps.sv
design/rmh_checker.sv
verif/running_median_two_heaps_test.sv
